[rtl/core/bpc_pkg.sv]
// Shared types and constants for the barometric pressure compensation core.
// No dependencies.
`default_nettype none
package bpc_pkg;
    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    localparam logic [1:0] ST_TEMP_STORED   = 2'd0;
    localparam logic [1:0] ST_TEMP_REJECTED = 2'd1;
    localparam logic [1:0] ST_PRESS_IN      = 2'd2;
    localparam logic [1:0] ST_PRESS_OUT     = 2'd3;

    localparam logic [2:0] REG_GROUP_A = 3'd0;
    localparam logic [2:0] REG_GROUP_B = 3'd1;
    localparam logic [2:0] REG_GROUP_C = 3'd2;
    localparam logic [2:0] REG_GROUP_D = 3'd3;
    localparam logic [2:0] REG_OSS     = 3'd4;

    localparam logic [31:0] K_B6_OFS  = 32'd4000;
    localparam logic [31:0] K_P1      = 32'd3038;
    localparam logic [31:0] K_P2      = 32'd7357;
    localparam logic [31:0] K_P3      = 32'd3791;
    localparam logic [31:0] K_B7_BASE = 32'd50000;
    localparam logic [31:0] K_HALF    = 32'd32768;
    localparam logic [31:0] K_MSB     = 32'h8000_0000;
    localparam logic signed [31:0] P_LO = 32'sd30000;
    localparam logic signed [31:0] P_HI = 32'sd120000;
endpackage
`default_nettype wire

[rtl/core/barometric_pressure_compensation_core.sv]
// Top level of the barometric pressure compensation core: sequencer with one
// shared 32x32 multiplier and a one-bit-per-cycle divider. Uses bpc_pkg.
`default_nettype none
// A temperature item (cmd 0) runs the temperature states and a pressure item
// (cmd 1) the pressure states: each product goes through the single shared
// multiplier one per cycle, and each division runs 32 restoring steps, one
// quotient bit a cycle. A temperature item with a zero denominator skips its
// division, as does a pressure item with zero B4. s_axis_tready is high only
// while the sequencer is idle. The result sits in an output register so the
// next item may be taken while it waits; the sequencer holds its own result
// back only while that register is still full.
module barometric_pressure_compensation_core
    import bpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] raw_sample
    input  wire logic        s_axis_tuser,   // [0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] pressure_pa, [33:32] status, [34] b5_stored
    output logic             m_axis_tuser    // unused flag, held at 0
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_T0 = 5'd1,  S_T1 = 5'd2,  S_TDIV = 5'd3,
                           S_TEND = 5'd4,  S_P0 = 5'd5,  S_P1 = 5'd6,  S_P2 = 5'd7,
                           S_P3 = 5'd8,    S_P4 = 5'd9,  S_P5 = 5'd10, S_P6 = 5'd11,
                           S_P7 = 5'd12,   S_PDIV = 5'd13, S_P8 = 5'd14, S_P9 = 5'd15,
                           S_P10 = 5'd16, S_P11 = 5'd17, S_OUT = 5'd18, S_P12 = 5'd19;

    logic [47:0] ga_reg, gb_reg;
    logic [31:0] gc_reg, gd_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg;
    logic        b5v_reg;
    logic [4:0]  state_reg;
    logic [23:0] raw_reg;
    logic [31:0] x1_reg, b6_reg, sq_reg, b3_reg, b4_reg, b7_reg, t_reg, p_reg;
    logic [31:0] num_reg, den_reg, quo_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [31:0] res_p_reg;
    logic [1:0]  res_s_reg;
    logic        out_v_reg;
    logic [31:0] out_p_reg;
    logic [1:0]  out_s_reg;
    logic        out_tv_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b, mul_y;
    assign mul_y = mul_a * mul_b;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction
    function automatic logic [31:0] sx(input logic [15:0] v);
        sx = {{16{v[15]}}, v};
    endfunction

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx(ga_reg[47:32]);
    assign ac2 = sx(ga_reg[31:16]);
    assign ac3 = sx(ga_reg[15:0]);
    assign ac4 = {16'd0, gb_reg[47:32]};
    assign ac5 = {16'd0, gb_reg[31:16]};
    assign ac6 = {16'd0, gb_reg[15:0]};
    assign b1  = sx(gc_reg[31:16]);
    assign b2  = sx(gc_reg[15:0]);
    assign mc  = sx(gd_reg[31:16]);
    assign md  = sx(gd_reg[15:0]);

    logic [31:0] up;
    assign up = 32'({8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg}));

    always_comb begin
        mul_a = b6_reg;
        mul_b = b6_reg;
        unique case (state_reg)
            S_T0:  begin mul_a = {16'd0, raw_reg[15:0]} - ac6; mul_b = ac5; end
            S_P0:  begin mul_a = b6_reg; mul_b = b6_reg; end
            S_P1:  begin mul_a = b2;     mul_b = sq_reg; end
            S_P2:  begin mul_a = ac2;    mul_b = b6_reg; end
            S_P3:  begin mul_a = ac3;    mul_b = b6_reg; end
            S_P4:  begin mul_a = b1;     mul_b = sq_reg; end
            S_P5:  begin mul_a = ac4;    mul_b = t_reg + K_HALF; end
            S_P6:  begin mul_a = up - b3_reg; mul_b = K_B7_BASE >> oss_reg; end
            S_P8:  begin mul_a = asr(p_reg, 5'd8); mul_b = asr(p_reg, 5'd8); end
            S_P9:  begin mul_a = t_reg;  mul_b = K_P1; end
            S_P10: begin mul_a = K_P2;   mul_b = p_reg; end
            default: ;
        endcase
    end

    // restoring divider step
    logic [32:0] rem_sh;
    logic        fits;
    assign rem_sh = {rem_reg[31:0], num_reg[31]};
    assign fits = rem_sh >= {1'b0, den_reg};

    logic [31:0] den_t, mag_t, quo_s;
    assign den_t = x1_reg + md;
    assign quo_s = neg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign mag_t = p_reg + asr(t_reg + x1_reg + K_P3, 5'd4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ga_reg <= '0; gb_reg <= '0; gc_reg <= '0; gd_reg <= '0;
            oss_reg <= 2'd1;
            b5_reg <= '0; b5v_reg <= 1'b0;
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_GROUP_A: ga_reg <= cfg_data;
                    REG_GROUP_B: gb_reg <= cfg_data;
                    REG_GROUP_C: gc_reg <= cfg_data[31:0];
                    REG_GROUP_D: gd_reg <= cfg_data[31:0];
                    REG_OSS:     oss_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    raw_reg <= s_axis_tdata;
                    b6_reg <= b5_reg - K_B6_OFS;
                    state_reg <= (s_axis_tuser == CMD_TEMP) ? S_T0 : S_P0;
                end
                S_T0: begin x1_reg <= asr(mul_y, 5'd15); state_reg <= S_T1; end
                S_T1: begin
                    if (den_t == '0) begin
                        res_p_reg <= '0; res_s_reg <= ST_TEMP_REJECTED;
                        state_reg <= S_OUT;
                    end else begin
                        // |MC*2048| fits 32 bits; truncated signed divide
                        num_reg <= mc[31] ? 32'(-(mc << 11)) : (mc << 11);
                        den_reg <= den_t[31] ? (32'd0 - den_t) : den_t;
                        neg_reg <= mc[31] ^ den_t[31];
                        rem_reg <= '0; quo_reg <= '0; cnt_reg <= 6'd0;
                        state_reg <= S_TDIV;
                    end
                end
                S_TDIV, S_PDIV: begin
                    rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                    quo_reg <= {quo_reg[30:0], fits};
                    num_reg <= {num_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                        state_reg <= (state_reg == S_TDIV) ? S_TEND : S_P12;
                end
                S_TEND: begin
                    b5_reg <= x1_reg + quo_s; b5v_reg <= 1'b1;
                    res_p_reg <= '0; res_s_reg <= ST_TEMP_STORED;
                    state_reg <= S_OUT;
                end
                S_P0: begin sq_reg <= asr(mul_y, 5'd12); state_reg <= S_P1; end
                S_P1: begin t_reg <= asr(mul_y, 5'd11); state_reg <= S_P2; end
                S_P2: begin
                    b3_reg <= asr((((ac1 << 2) + t_reg + asr(mul_y, 5'd11)) << oss_reg)
                                  + 32'd2, 5'd2);
                    state_reg <= S_P3;
                end
                S_P3: begin t_reg <= asr(mul_y, 5'd13); state_reg <= S_P4; end
                S_P4: begin t_reg <= asr(t_reg + asr(mul_y, 5'd16) + 32'd2, 5'd2);
                    state_reg <= S_P5; end
                S_P5: begin b4_reg <= mul_y >> 15; state_reg <= S_P6; end
                S_P6: begin b7_reg <= mul_y; state_reg <= S_P7; end
                S_P7: begin
                    if (b4_reg == '0) begin
                        res_p_reg <= '0; res_s_reg <= ST_PRESS_OUT; state_reg <= S_OUT;
                    end else begin
                        num_reg <= (b7_reg < K_MSB) ? (b7_reg << 1) : b7_reg;
                        den_reg <= b4_reg;
                        rem_reg <= '0; quo_reg <= '0; cnt_reg <= 6'd0;
                        state_reg <= S_PDIV;
                    end
                end
                S_P12: begin
                    p_reg <= (b7_reg < K_MSB) ? quo_reg : (quo_reg << 1);
                    state_reg <= S_P8;
                end
                S_P8: begin t_reg <= mul_y; state_reg <= S_P9; end
                S_P9: begin t_reg <= asr(mul_y, 5'd16); state_reg <= S_P10; end
                S_P10: begin x1_reg <= asr(32'd0 - mul_y, 5'd16); state_reg <= S_P11; end
                S_P11: begin
                    res_p_reg <= mag_t;
                    res_s_reg <= ($signed(mag_t) > P_LO && $signed(mag_t) < P_HI)
                                 ? ST_PRESS_IN : ST_PRESS_OUT;
                    state_reg <= S_OUT;
                end
                S_OUT: if (!out_v_reg || m_axis_tready) begin
                    out_p_reg <= res_p_reg;
                    out_s_reg <= res_s_reg;
                    out_tv_reg <= b5v_reg;
                    out_v_reg <= 1'b1; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {5'd0, out_tv_reg, out_s_reg, out_p_reg};
    assign m_axis_tuser  = 1'b0;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while waiting");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TDIV) |-> (cnt_reg < 6'd32)) else $error("divider overrun");
endmodule
`default_nettype wire
